FILE: design/jtl_pkg.sv
package jtl_pkg;

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] TAG_LBRACK = 4'd0;
    localparam logic [3:0] TAG_RBRACK = 4'd1;
    localparam logic [3:0] TAG_LBRACE = 4'd2;
    localparam logic [3:0] TAG_RBRACE = 4'd3;
    localparam logic [3:0] TAG_COMMA  = 4'd4;
    localparam logic [3:0] TAG_COLON  = 4'd5;
    localparam logic [3:0] TAG_QUOTE  = 4'd6;
    localparam logic [3:0] TAG_WORD   = 4'd7;
    localparam logic [3:0] TAG_TRUE   = 4'd8;
    localparam logic [3:0] TAG_FALSE  = 4'd9;
    localparam logic [3:0] TAG_NULL   = 4'd10;
    localparam logic [3:0] TAG_NUM    = 4'd11;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;
    localparam logic [1:0] MODE_DROP = 2'd3;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  tag;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic        run_end;
    } result_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || (b == 8'h5F);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A);
    endfunction

    // delimiter tag, bit 4 set when the byte is no delimiter
    function automatic logic [4:0] delim_code(input logic [7:0] b);
        logic [4:0] d;
        case (b)
            8'h5B:   d = {1'b0, TAG_LBRACK};
            8'h5D:   d = {1'b0, TAG_RBRACK};
            8'h7B:   d = {1'b0, TAG_LBRACE};
            8'h7D:   d = {1'b0, TAG_RBRACE};
            8'h2C:   d = {1'b0, TAG_COMMA};
            8'h3A:   d = {1'b0, TAG_COLON};
            8'h22:   d = {1'b0, TAG_QUOTE};
            default: d = 5'h10;
        endcase
        return d;
    endfunction

    // bit 8 marks a position past the end of the keyword
    function automatic logic [8:0] kw_char(input logic [1:0] k, input logic [2:0] at);
        logic [8:0] c;
        c = 9'h100;
        case (k)
            2'd0:
            begin
                case (at)
                    3'd0:    c = 9'h074;
                    3'd1:    c = 9'h072;
                    3'd2:    c = 9'h075;
                    3'd3:    c = 9'h065;
                    default: c = 9'h100;
                endcase
            end
            2'd1:
            begin
                case (at)
                    3'd0:    c = 9'h066;
                    3'd1:    c = 9'h061;
                    3'd2:    c = 9'h06C;
                    3'd3:    c = 9'h073;
                    3'd4:    c = 9'h065;
                    default: c = 9'h100;
                endcase
            end
            2'd2:
            begin
                case (at)
                    3'd0:    c = 9'h06E;
                    3'd1:    c = 9'h075;
                    3'd2:    c = 9'h06C;
                    3'd3:    c = 9'h06C;
                    default: c = 9'h100;
                endcase
            end
            default: c = 9'h100;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_match(input logic [2:0] cand, input logic [15:0] at,
                                           input logic [7:0] b);
        logic [2:0] r;
        r = cand;
        for (int k = 0; k < 3; k++)
        begin
            if (at > 16'd7 || kw_char(2'(k), at[2:0]) != {1'b0, b})
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [3:0] word_tag(input logic [2:0] cand, input logic [15:0] len);
        logic [3:0] t;
        t = TAG_WORD;
        if (cand[0] && len == 16'd4)
            t = TAG_TRUE;
        if (cand[1] && len == 16'd5)
            t = TAG_FALSE;
        if (cand[2] && len == 16'd4)
            t = TAG_NULL;
        return t;
    endfunction

endpackage

FILE: design/jtl_core.sv
module jtl_core
    import jtl_pkg::*;
#(
    parameter logic [15:0] POS_LIMIT = 16'hFFFF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic [7:0]                       byte_in,
    input  logic                             doc_end,
    output result_t [MAX_RESULTS-1:0]        res,
    output logic [1:0]                       res_count
);

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] pst_reg, pst_next;
    logic [15:0] plen_reg, plen_next;
    logic [2:0]  cand_reg, cand_next;

    always_comb
    begin
        result_t    r [MAX_RESULTS];
        logic [1:0] n;
        logic       used;
        logic [4:0] dc;

        for (int i = 0; i < MAX_RESULTS; i++)
            r[i] = '0;
        n = 2'd0;
        used = 1'b0;
        dc = delim_code(byte_in);
        mode_next = mode_reg;
        pos_next = pos_reg;
        pst_next = pst_reg;
        plen_next = plen_reg;
        cand_next = cand_reg;

        if (mode_reg == MODE_DROP)
        begin
            if (doc_end)
            begin
                mode_next = MODE_IDLE;
                pos_next = '0;
                pst_next = '0;
                plen_next = '0;
                cand_next = '0;
            end
            else if (pos_reg < POS_LIMIT)
            begin
                pos_next = pos_reg + 16'd1;
            end
        end
        else
        begin
            // extend or close the open word or number
            if (mode_reg == MODE_WORD || mode_reg == MODE_NUM)
            begin
                if ((mode_reg == MODE_WORD && (is_alpha(byte_in) || is_digit(byte_in))) ||
                    (mode_reg == MODE_NUM && (is_digit(byte_in) || byte_in == 8'h2E)))
                begin
                    if (mode_reg == MODE_WORD)
                        cand_next = kw_match(cand_reg, plen_reg, byte_in);
                    if (plen_reg != LEN_MAX)
                        plen_next = plen_reg + 16'd1;
                    used = 1'b1;
                end
                else
                begin
                    r[n] = '{KIND_TOKEN,
                             (mode_reg == MODE_WORD) ? word_tag(cand_reg, plen_reg) : TAG_NUM,
                             pst_reg, plen_reg, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                    plen_next = '0;
                    cand_next = '0;
                end
            end

            if (!used)
            begin
                if (!dc[4])
                begin
                    r[n] = '{KIND_TOKEN, dc[3:0], pos_reg, 16'd1, 1'b0};
                    n = n + 2'd1;
                end
                else if (is_space(byte_in))
                begin
                    n = n;
                end
                else if (is_alpha(byte_in))
                begin
                    mode_next = MODE_WORD;
                    pst_next = pos_reg;
                    cand_next = kw_match(3'b111, 16'd0, byte_in);
                    plen_next = 16'd1;
                end
                else if (is_digit(byte_in))
                begin
                    mode_next = MODE_NUM;
                    pst_next = pos_reg;
                    plen_next = 16'd1;
                    cand_next = '0;
                end
                else
                begin
                    r[n] = '{KIND_ERROR, 4'd0, pos_reg, 16'd1, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_DROP;
                end
            end

            if (doc_end)
            begin
                if (mode_next == MODE_WORD || mode_next == MODE_NUM)
                begin
                    r[n] = '{KIND_TOKEN,
                             (mode_next == MODE_WORD) ? word_tag(cand_next, plen_next) : TAG_NUM,
                             pst_next, plen_next, 1'b0};
                    n = n + 2'd1;
                end
                if (mode_next != MODE_DROP)
                begin
                    r[n] = '{KIND_END, 4'd0, pos_reg, 16'd0, 1'b0};
                    n = n + 2'd1;
                end
                mode_next = MODE_IDLE;
                pos_next = '0;
                pst_next = '0;
                plen_next = '0;
                cand_next = '0;
            end
            else if (pos_reg < POS_LIMIT)
            begin
                pos_next = pos_reg + 16'd1;
            end

            if (n != 2'd0)
                r[n - 2'd1].run_end = 1'b1;
        end

        for (int i = 0; i < MAX_RESULTS; i++)
            res[i] = r[i];
        res_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg <= '0;
            pst_reg <= '0;
            plen_reg <= '0;
            cand_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            pst_reg <= pst_next;
            plen_reg <= plen_next;
            cand_reg <= cand_next;
        end
    end

endmodule

FILE: design/jtl_queue.sv
module jtl_queue
    import jtl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  result_t [MAX_RESULTS-1:0] push_data,
    input  logic [1:0]                push_count,
    output logic                      room,
    output logic                      out_valid,
    input  logic                      out_ready,
    output result_t                   out_data
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW = $clog2(QUEUE_DEPTH);

    result_t       q_reg [QUEUE_DEPTH];
    result_t       q_next [QUEUE_DEPTH];
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        logic [CW-1:0] base;

        base = count_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_next[i] = q_reg[i];

        if (out_valid && out_ready)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                q_next[i] = q_reg[i + 1];
            base = count_reg - CW'(1);
        end

        count_next = base;
        if (push)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                if (2'(i) < push_count)
                    q_next[IW'(base + CW'(i))] = push_data[i];
            end
            count_next = base + CW'(push_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    assign room = (count_reg <= CW'(QUEUE_DEPTH - MAX_RESULTS));
    assign out_valid = (count_reg != '0);
    assign out_data = q_reg[0];

endmodule

FILE: design/json_token_lexer.sv
// Byte-serial JSON token lexer. One document byte is taken per transfer on s_axis, with tlast on
// the final byte; tokens, the end mark and the error mark leave on m_axis, kind in tuser and the
// last result of each byte flagged by tlast. A byte is lexed in the cycle it is taken and its
// results (up to three) go into a four-entry result queue that feeds the output. One byte per
// cycle is sustained while each byte gives at most one result and m_axis does not stall; a byte
// that closes a word or number and also gives its own token, or a final byte, slows the input,
// since the queue drains one result per cycle and takes a byte only when it has room for three.
module json_token_lexer
    import jtl_pkg::*;
#(
    parameter int unsigned MAX_DOC_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // tag, start_offset, token_length, zero pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    localparam logic [15:0] POS_LIMIT = (MAX_DOC_BYTES - 1 > 65535) ? 16'hFFFF
                                        : 16'(MAX_DOC_BYTES - 1);

    logic                      fire;
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                res_count;
    logic                      room;
    result_t                   head;

    assign s_axis_tready = room;
    assign fire = s_axis_tvalid && room;

    jtl_core #(
        .POS_LIMIT (POS_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_in   (s_axis_tdata),
        .doc_end   (s_axis_tlast),
        .res       (res),
        .res_count (res_count)
    );

    jtl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_data  (res),
        .push_count (res_count),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (head)
    );

    assign m_axis_tdata = {4'd0, head.token_length, head.start_offset, head.tag};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.run_end;

endmodule

FILE: tb/json_token_lexer_tb.sv
module json_token_lexer_tb;
    import jtl_pkg::*;

    localparam int unsigned DOC_BYTES = 65536;
    localparam logic [15:0] POS_CAP =
        (DOC_BYTES - 1 > 65535) ? 16'hFFFF : 16'(DOC_BYTES - 1);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 140;
    localparam int DIR_ROWS = 30;
    localparam int DRAIN_CYCLES = 32;
    localparam logic [3:0] NO_TAG = 4'd0;
    localparam logic [55:0] DELIM_SET = "[]{},:\"";
    localparam logic [23:0] BLANK_SET = " \t\n";

    typedef struct {
        logic [7:0] b;
        logic       lst;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;   // tag, start_offset, token_length, zero pad
    logic [1:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;

    // lexer state as the block should hold it
    logic [1:0]  lx_mode;
    logic [15:0] lx_pos;
    logic [15:0] lx_start;
    logic [15:0] lx_len;
    string       lx_head;

    result_t     step_q[$];
    result_t     token_q[$];
    result_t     head;
    logic [7:0]  doc_q[$];
    string       kw_words[3] = '{"true", "false", "null"};

    int          fails = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          rx_hold = 0;
    int          rx_pick;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    stim_row_t dir_rows[DIR_ROWS] = '{
        '{"{",   1'b0, 1'b1, '{KIND_TOKEN, TAG_LBRACE, 16'd0, 16'd1, 1'b1}},
        '{"\"",  1'b0, 1'b0, '0},
        '{"\t",  1'b0, 1'b0, '0},
        '{"f",   1'b0, 1'b0, '0},
        '{"a",   1'b0, 1'b0, '0},
        '{"l",   1'b0, 1'b0, '0},
        '{"s",   1'b0, 1'b0, '0},
        '{"e",   1'b1, 1'b0, '0},
        '{"8",   1'b0, 1'b0, '0},
        '{".",   1'b0, 1'b0, '0},
        '{"t",   1'b0, 1'b0, '0},
        '{"r",   1'b0, 1'b0, '0},
        '{"u",   1'b0, 1'b0, '0},
        '{"e",   1'b0, 1'b0, '0},
        '{",",   1'b0, 1'b0, '0},
        '{":",   1'b0, 1'b0, '0},
        '{" ",   1'b0, 1'b0, '0},
        '{"\n",  1'b0, 1'b0, '0},
        '{"]",   1'b1, 1'b0, '0},
        '{"n",   1'b0, 1'b0, '0},
        '{"u",   1'b0, 1'b0, '0},
        '{"l",   1'b0, 1'b0, '0},
        '{"l",   1'b0, 1'b0, '0},
        '{"}",   1'b0, 1'b0, '0},
        '{"Z",   1'b0, 1'b0, '0},
        '{".",   1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{KIND_ERROR, NO_TAG, 16'd0, 16'd1, 1'b1}},
        '{".",   1'b0, 1'b1, '{KIND_ERROR, NO_TAG, 16'd0, 16'd1, 1'b1}},
        '{"x",   1'b1, 1'b0, '0}
    };

    json_token_lexer #(
        .MAX_DOC_BYTES(DOC_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == " " || b == "\t" || b == "\n";
    endfunction

    function automatic void lex_clear();
        lx_mode = MODE_IDLE;
        lx_pos = '0;
        lx_start = '0;
        lx_len = '0;
        lx_head = "";
    endfunction

    function automatic void put_result(input logic [1:0] kind, input logic [3:0] tag,
                                       input logic [15:0] off, input logic [15:0] len);
        result_t r;
        r.kind = kind;
        r.tag = tag;
        r.start_offset = off;
        r.token_length = len;
        r.run_end = 1'b0;
        step_q.push_back(r);
    endfunction

    // only the first five bytes of a word matter for the keyword tags
    function automatic void close_pending();
        logic [3:0] tag;
        tag = TAG_NUM;
        if (lx_mode == MODE_WORD)
        begin
            tag = TAG_WORD;
            if (lx_len == 16'd4 && lx_head == "true")
                tag = TAG_TRUE;
            if (lx_len == 16'd5 && lx_head == "false")
                tag = TAG_FALSE;
            if (lx_len == 16'd4 && lx_head == "null")
                tag = TAG_NULL;
        end
        put_result(KIND_TOKEN, tag, lx_start, lx_len);
        lx_mode = MODE_IDLE;
        lx_len = '0;
        lx_head = "";
    endfunction

    function automatic void lex_predict(input logic [7:0] b, input logic lst);
        bit         taken;
        bit         delim;
        logic [3:0] dtag;
        step_q.delete();
        taken = 1'b0;
        if (lx_mode == MODE_DROP)
        begin
            if (lst)
                lex_clear();
            else if (lx_pos < POS_CAP)
                lx_pos++;
            return;
        end
        if (lx_mode == MODE_WORD)
        begin
            if (is_letter(b) || is_num(b))
            begin
                if (lx_head.len() < 5)
                    lx_head = $sformatf("%s%c", lx_head, b);
                if (lx_len != LEN_MAX)
                    lx_len++;
                taken = 1'b1;
            end
            else
                close_pending();
        end
        else if (lx_mode == MODE_NUM)
        begin
            if (is_num(b) || b == ".")
            begin
                if (lx_len != LEN_MAX)
                    lx_len++;
                taken = 1'b1;
            end
            else
                close_pending();
        end
        if (!taken)
        begin
            delim = 1'b1;
            case (b)
                "[":     dtag = TAG_LBRACK;
                "]":     dtag = TAG_RBRACK;
                "{":     dtag = TAG_LBRACE;
                "}":     dtag = TAG_RBRACE;
                ",":     dtag = TAG_COMMA;
                ":":     dtag = TAG_COLON;
                "\"":    dtag = TAG_QUOTE;
                default:
                begin
                    delim = 1'b0;
                    dtag = NO_TAG;
                end
            endcase
            if (delim)
                put_result(KIND_TOKEN, dtag, lx_pos, 16'd1);
            else if (is_letter(b))
            begin
                lx_mode = MODE_WORD;
                lx_start = lx_pos;
                lx_len = 16'd1;
                lx_head = $sformatf("%c", b);
            end
            else if (is_num(b))
            begin
                lx_mode = MODE_NUM;
                lx_start = lx_pos;
                lx_len = 16'd1;
                lx_head = "";
            end
            else if (!is_blank(b))
            begin
                put_result(KIND_ERROR, NO_TAG, lx_pos, 16'd1);
                lx_mode = MODE_DROP;
            end
        end
        if (lst)
        begin
            if (lx_mode == MODE_WORD || lx_mode == MODE_NUM)
                close_pending();
            if (lx_mode != MODE_DROP)
                put_result(KIND_END, NO_TAG, lx_pos, 16'd0);
            lex_clear();
        end
        else if (lx_pos < POS_CAP)
            lx_pos++;
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].run_end = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 3) == 0)
            return rand_digit();
        return rand_letter();
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
                             input result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        lex_predict(b, lst);
        if (typed)
            token_q.push_back(want);
        else
            foreach (step_q[i])
                token_q.push_back(step_q[i]);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (token_q.size() != 0);
    endtask

    // mostly well-formed pieces, with some bad bytes and raw noise
    task automatic make_doc();
        int    r;
        int    n;
        int    i;
        string w;
        doc_q.delete();
        repeat ($urandom_range(1, 8))
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                doc_q.push_back(DELIM_SET[8 * $urandom_range(0, 6) +: 8]);
            else if (r < 40)
                repeat ($urandom_range(1, 3))
                    doc_q.push_back(BLANK_SET[8 * $urandom_range(0, 2) +: 8]);
            else if (r < 65)
            begin
                w = kw_words[$urandom_range(0, 2)];
                n = $urandom_range(0, 3);
                if (n == 1)
                    w = w.substr(0, $urandom_range(0, w.len() - 2));
                else if (n == 2)
                    w = $sformatf("%s%c", w, rand_alnum());
                else if (n == 3)
                begin
                    w = $sformatf("%c", rand_letter());
                    repeat ($urandom_range(0, 6))
                        w = $sformatf("%s%c", w, rand_alnum());
                end
                for (i = 0; i < w.len(); i++)
                    doc_q.push_back(w[i]);
            end
            else if (r < 85)
            begin
                doc_q.push_back(rand_digit());
                repeat ($urandom_range(0, 5))
                    doc_q.push_back(($urandom_range(0, 3) == 0) ? 8'(".") : rand_digit());
            end
            else if (r < 92)
            begin
                n = $urandom_range(0, 2);
                if (n == 0)
                    doc_q.push_back(".");
                else if (n == 1)
                    doc_q.push_back("-");
                else
                    doc_q.push_back(8'($urandom_range(128, 255)));
            end
            else
                doc_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        else if (rx_calm)
            m_axis_tready <= 1'b1;
        else
        begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 70)
            begin
                m_axis_tready <= 1'b1;
                rx_hold = $urandom_range(0, 7);
            end
            else if (rx_pick < 95)
            begin
                m_axis_tready <= 1'b0;
                rx_hold = $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                rx_hold = $urandom_range(10, 40);
            end
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (token_q.size() == 0)
            begin
                $error("result with none expected: kind %0d tag %0d offset %0d",
                       m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]);
                fails++;
            end
            else
            begin
                head = token_q.pop_front();
                check_field("kind", head.kind, m_axis_tuser);
                check_field("tag", head.tag, m_axis_tdata[3:0]);
                check_field("start_offset", head.start_offset, m_axis_tdata[19:4]);
                check_field("token_length", head.token_length, m_axis_tdata[35:20]);
                check_field("run_end", head.run_end, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("json_token_lexer regression: fail");
            $finish;
        end
    end

    initial
    begin
        int k;
        lex_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            send_byte(dir_rows[k].b, dir_rows[k].lst, dir_rows[k].typed, dir_rows[k].want);

        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            make_doc();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                drain_results();
            foreach (doc_q[i])
                send_byte(doc_q[i], i == doc_q.size() - 1, 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("json_token_lexer regression: pass");
        else
            $display("json_token_lexer regression: fail");
        $finish;
    end

endmodule
